/* design/bce_pkg.sv */
// Package for the four-band Bezier crossover equalizer.
// Holds widths, register indexes, reset values, sequencer states and saturation.
// No dependencies.
`default_nettype none
package bce_pkg;

   localparam int PASSES_DEF      = 3;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int PT_W            = 40;   // history point width
   localparam int ACC_W           = 72;   // accumulator width
   localparam int MA_W            = 48;   // multiplier operand A
   localparam int MB_W            = 18;   // multiplier operand B
   localparam int PROD_W          = MA_W + MB_W;
   localparam int SHRINK_K        = 5374; // 0.082 in Q0.16
   localparam int CSR_IDX_W       = 4;
   localparam int CSR_DATA_W      = 64;

   localparam logic [63:0] GAINS_RST = 64'h4000_4000_4000_4000;
   localparam logic [47:0] Q_RST     = 48'h35C3_35C3_35C3;
   localparam logic [31:0] STEP_RST  = 32'h8000_0000;
   localparam logic [31:0] TRIM_RST  = 32'hAAAA_AAAA;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAINS   = 4'd0,
      CSR_Q       = 4'd1,
      CSR_HM_STEP = 4'd2,
      CSR_HM_TRIM = 4'd3,
      CSR_M_STEP  = 4'd4,
      CSR_M_TRIM  = 4'd5,
      CSR_LM_STEP = 4'd6,
      CSR_LM_TRIM = 4'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, PH_SUM, PH_F, ST_RD, ST_LO, ST_ACC, ST_FM, ST_SHIFT,
      ST_WD, ST_WC, ST_WB, ST_BD, ST_BC, ST_BB, ST_BE, ST_Q, ST_OUT,
      ST_MX, ST_MXE, ST_DONE
   } seq_state_type;

   // Clamp a signed value to a signed range of the given width.
   function automatic logic signed [ACC_W-1:0] sat_w(input logic signed [ACC_W-1:0] v,
                                                     input int bits);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = (ACC_W'(1) <<< (bits - 1)) - ACC_W'(1);
      lo = ~hi;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

/* design/bce_ifs.sv */
// Channel interfaces: request, response and register write.
// Depends on bce_pkg.
`default_nettype none
interface bce_req_if #(parameter int SAMPLE_BITS = bce_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_left;
   logic signed [SAMPLE_BITS-1:0] sample_right;
   modport source (output valid, sample_left, sample_right, input ready);
   modport sink (input valid, sample_left, sample_right, output ready);
endinterface

interface bce_rsp_if #(parameter int SAMPLE_BITS = bce_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;
   modport source (output valid, out_left, out_right, input ready);
   modport sink (input valid, out_left, out_right, output ready);
endinterface

interface bce_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bce_pkg::CSR_IDX_W-1:0]    index;
   logic [bce_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/bce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

/* design/bce_mul.sv */
// Shared signed multiplier with registered product.
// Depends on bce_pkg.
`default_nettype none
module bce_mul (
   input  wire logic                              clock,
   input  wire logic signed [bce_pkg::MA_W-1:0]   op_a,
   input  wire logic signed [bce_pkg::MB_W-1:0]   op_b,
   output logic      signed [bce_pkg::PROD_W-1:0] prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end
endmodule
`default_nettype wire

/* design/bezier_crossover_four_band_eq.sv */
// Top level of the four-band Bezier crossover equalizer.
// Depends on bce_pkg, bce_ifs, bce_mul and bce_ram.
//
//   channel    | dir | payload                          | accepted when
//   req_chan   | in  | sample_left, sample_right        | valid & ready
//   rsp_chan   | out | out_left, out_right              | valid & ready
//   csr_chan   | in  | index, data (register write)     | valid & ready (ready always high)
//
// Every multiply of the stage updates and the band mixes goes through the one
// registered multiplier, one product per cycle; a history shift adds the states
// ST_FM and ST_SHIFT to its stage update.
// Synchronous reset clears control, phases and history valid bits; history reads
// as zero until first written. req_chan.ready is high only in idle; a finished
// response holds in its register until rsp_chan takes it.
`default_nettype none
module bezier_crossover_four_band_eq #(
   parameter int PASSES      = bce_pkg::PASSES_DEF,
   parameter int SAMPLE_BITS = bce_pkg::SAMPLE_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   bce_req_if.sink   req_chan,
   bce_rsp_if.source rsp_chan,
   bce_csr_if.sink   csr_chan
);
   localparam int SIG_W  = SAMPLE_BITS + 8;
   localparam int PW     = $clog2(PASSES + 1);
   localparam int PH_N   = 3 * PASSES;
   localparam int PHW    = $clog2(PH_N);
   localparam int RAM_D  = 6 * PASSES;
   localparam int AW     = $clog2(RAM_D);
   localparam int WORD_W = 4 * bce_pkg::PT_W;
   localparam int AC     = bce_pkg::ACC_W;
   localparam int PT     = bce_pkg::PT_W;

   // configuration registers
   logic [63:0] gains_ff;
   logic [47:0] q_ff;
   logic [31:0] step_ff [3];
   logic [31:0] trim_ff [3];

   // sequencer
   bce_pkg::seq_state_type state_ff, state_in;
   logic [PW-1:0] p_ff;
   logic          ch_ff;
   logic [1:0]    s_ff;
   logic [1:0]    k_ff;

   // datapath
   logic signed [SIG_W-1:0] x_ff [2];
   logic signed [SIG_W-1:0] in_ff;
   logic signed [SIG_W-1:0] band_ff [4];
   logic                    fire_ff [3];
   logic [31:0]             ph_ff [3];
   logic signed [17:0]      f_ff [3];
   logic signed [PT-1:0]    pa_ff, pn_ff, pm_ff, po_ff;
   logic signed [17:0]      w0_ff, w1_ff, w2_ff;
   logic signed [AC-1:0]    acc_ff;
   logic [31:0]             phase_ff [PH_N];
   logic [RAM_D-1:0]        valid_ff;
   logic                    rvalid_ff;
   logic                    rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_left_ff, out_right_ff;

   // shared multiplier and history memory
   logic signed [bce_pkg::MA_W-1:0]   mul_a;
   logic signed [bce_pkg::MB_W-1:0]   mul_b;
   logic signed [bce_pkg::PROD_W-1:0] prod;
   logic [AW-1:0]     ram_addr;
   logic [WORD_W-1:0] ram_rdata;
   logic              ram_we;

   bce_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod));

   bce_ram #(.WIDTH(WORD_W), .DEPTH(RAM_D)) u_hist (
      .clock(clock), .we(ram_we), .waddr(ram_addr),
      .wdata({pa_ff, pn_ff, pm_ff, po_ff}), .raddr(ram_addr), .rdata(ram_rdata)
   );

   // working values
   logic [31:0]          cur_step;
   logic [31:0]          ph_step;
   logic [PHW-1:0]       ph_idx;
   logic [32:0]          ph_sum;
   logic                 ph_fire;
   logic [16:0]          u_w, v_w;
   logic signed [AC-1:0] prod_x, t_val, anew_w, o_w, band_w, mix_w, mixo_w;
   logic signed [AC-1:0] acc_sh16;

   assign cur_step = step_ff[s_ff];
   assign ph_step  = step_ff[k_ff];
   assign ph_idx   = PHW'(p_ff * 3 + k_ff);
   assign ph_sum   = {1'b0, phase_ff[ph_idx]} + {1'b0, ph_step};
   assign ph_fire  = ph_sum > {1'b0, trim_ff[k_ff]};
   assign ram_addr = AW'(p_ff * 6 + s_ff * 2 + ch_ff);
   assign u_w      = {1'b0, ph_ff[s_ff][31:16]};
   assign v_w      = 17'h10000 - u_w;
   assign prod_x   = AC'(prod);
   assign t_val    = (acc_ff + (prod_x >>> 16)) >>> 16;
   assign anew_w   = bce_pkg::sat_w(AC'(pa_ff) + t_val, PT);
   assign acc_sh16 = acc_ff >>> 16;
   assign o_w      = bce_pkg::sat_w(prod_x >>> 14, SIG_W);
   assign band_w   = bce_pkg::sat_w(AC'(in_ff) - o_w, SIG_W);
   assign mix_w    = acc_ff + prod_x;
   assign mixo_w   = bce_pkg::sat_w(mix_w >>> 14, SIG_W);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bce_pkg::ST_IDLE:  if (req_chan.valid) state_in = bce_pkg::PH_SUM;
         bce_pkg::PH_SUM:   state_in = bce_pkg::PH_F;
         bce_pkg::PH_F:     state_in = (k_ff == 2'd2) ? bce_pkg::ST_RD : bce_pkg::PH_SUM;
         bce_pkg::ST_RD:    state_in = bce_pkg::ST_LO;
         bce_pkg::ST_LO:    state_in = bce_pkg::ST_ACC;
         bce_pkg::ST_ACC:   state_in = fire_ff[s_ff] ? bce_pkg::ST_FM : bce_pkg::ST_WD;
         bce_pkg::ST_FM:    state_in = bce_pkg::ST_SHIFT;
         bce_pkg::ST_SHIFT: state_in = bce_pkg::ST_WD;
         bce_pkg::ST_WD:    state_in = bce_pkg::ST_WC;
         bce_pkg::ST_WC:    state_in = bce_pkg::ST_WB;
         bce_pkg::ST_WB:    state_in = bce_pkg::ST_BD;
         bce_pkg::ST_BD:    state_in = bce_pkg::ST_BC;
         bce_pkg::ST_BC:    state_in = bce_pkg::ST_BB;
         bce_pkg::ST_BB:    state_in = bce_pkg::ST_BE;
         bce_pkg::ST_BE:    state_in = bce_pkg::ST_Q;
         bce_pkg::ST_Q:     state_in = bce_pkg::ST_OUT;
         bce_pkg::ST_OUT:   state_in = (s_ff == 2'd2) ? bce_pkg::ST_MX : bce_pkg::ST_RD;
         bce_pkg::ST_MX:    state_in = (k_ff == 2'd3) ? bce_pkg::ST_MXE : bce_pkg::ST_MX;
         bce_pkg::ST_MXE: begin
            if (!ch_ff) state_in = bce_pkg::ST_RD;
            else if (p_ff == PW'(PASSES - 1)) state_in = bce_pkg::ST_DONE;
            else state_in = bce_pkg::PH_SUM;
         end
         bce_pkg::ST_DONE:  if (rsp_chan.ready) state_in = bce_pkg::ST_IDLE;
         default:           state_in = bce_pkg::ST_IDLE;
      endcase
   end

   // outputs: multiplier operands, memory write, handshakes
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      ram_we = 1'b0;
      unique case (state_ff)
         bce_pkg::PH_SUM: begin
            mul_a = bce_pkg::MA_W'(ph_step);
            mul_b = bce_pkg::MB_W'(bce_pkg::SHRINK_K);
         end
         bce_pkg::ST_RD: begin
            mul_a = bce_pkg::MA_W'(in_ff);
            mul_b = bce_pkg::MB_W'(cur_step[31:16]);
         end
         bce_pkg::ST_LO: begin
            mul_a = bce_pkg::MA_W'(in_ff);
            mul_b = bce_pkg::MB_W'(cur_step[15:0]);
         end
         bce_pkg::ST_FM: begin
            mul_a = bce_pkg::MA_W'(pa_ff);
            mul_b = f_ff[s_ff];
         end
         bce_pkg::ST_WD: begin
            mul_a = bce_pkg::MA_W'(v_w);
            mul_b = bce_pkg::MB_W'(v_w);
         end
         bce_pkg::ST_WC: begin
            mul_a = bce_pkg::MA_W'(u_w);
            mul_b = bce_pkg::MB_W'(v_w);
         end
         bce_pkg::ST_WB: begin
            mul_a = bce_pkg::MA_W'(u_w);
            mul_b = bce_pkg::MB_W'(u_w);
         end
         bce_pkg::ST_BD: begin
            mul_a = bce_pkg::MA_W'(po_ff);
            mul_b = w0_ff;
         end
         bce_pkg::ST_BC: begin
            mul_a = bce_pkg::MA_W'(pm_ff);
            mul_b = w1_ff;
         end
         bce_pkg::ST_BB: begin
            mul_a = bce_pkg::MA_W'(pn_ff);
            mul_b = w2_ff;
         end
         bce_pkg::ST_Q: begin
            mul_a = acc_sh16[bce_pkg::MA_W-1:0];
            mul_b = bce_pkg::MB_W'($signed(q_ff[16 * s_ff +: 16]));
         end
         bce_pkg::ST_OUT: ram_we = 1'b1;
         bce_pkg::ST_MX: begin
            mul_a = bce_pkg::MA_W'(band_ff[k_ff]);
            mul_b = bce_pkg::MB_W'($signed(gains_ff[16 * k_ff +: 16]));
         end
         default: ;
      endcase
   end

   assign req_chan.ready     = (state_ff == bce_pkg::ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_left  = out_left_ff;
   assign rsp_chan.out_right = out_right_ff;
   assign csr_chan.ready     = 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bce_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         for (int i = 0; i < PH_N; i++) phase_ff[i] <= '0;
         gains_ff     <= bce_pkg::GAINS_RST;
         q_ff         <= bce_pkg::Q_RST;
         for (int i = 0; i < 3; i++) begin
            step_ff[i] <= bce_pkg::STEP_RST;
            trim_ff[i] <= bce_pkg::TRIM_RST;
         end
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               bce_pkg::CSR_GAINS:   gains_ff   <= csr_chan.data;
               bce_pkg::CSR_Q:       q_ff       <= csr_chan.data[47:0];
               bce_pkg::CSR_HM_STEP: step_ff[0] <= csr_chan.data[31:0];
               bce_pkg::CSR_HM_TRIM: trim_ff[0] <= csr_chan.data[31:0];
               bce_pkg::CSR_M_STEP:  step_ff[1] <= csr_chan.data[31:0];
               bce_pkg::CSR_M_TRIM:  trim_ff[1] <= csr_chan.data[31:0];
               bce_pkg::CSR_LM_STEP: step_ff[2] <= csr_chan.data[31:0];
               bce_pkg::CSR_LM_TRIM: trim_ff[2] <= csr_chan.data[31:0];
               default: ;  // drop writes beyond the register list
            endcase
         end
         if (state_ff == bce_pkg::PH_SUM) begin
            phase_ff[ph_idx] <= ph_fire ? 32'd0 : ph_sum[31:0];
         end
         if (state_ff == bce_pkg::ST_OUT) valid_ff[ram_addr] <= 1'b1;
         if (state_ff == bce_pkg::ST_MXE && ch_ff && p_ff == PW'(PASSES - 1)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath and counters
   always_ff @(posedge clock) begin
      case (state_ff)
         bce_pkg::ST_IDLE: begin
            x_ff[0] <= SIG_W'(req_chan.sample_left);
            x_ff[1] <= SIG_W'(req_chan.sample_right);
            p_ff    <= '0;
            k_ff    <= '0;
         end
         bce_pkg::PH_SUM: begin
            fire_ff[k_ff] <= ph_fire;
            ph_ff[k_ff]   <= ph_fire ? 32'd0 : ph_sum[31:0];
         end
         bce_pkg::PH_F: begin
            // f = 0.5 - 0.082 * step in Q0.16
            f_ff[k_ff] <= 18'sd32768 - 18'(prod[44:32]);
            k_ff       <= k_ff + 2'd1;
            s_ff       <= '0;
            ch_ff      <= 1'b0;
            in_ff      <= x_ff[0];
         end
         bce_pkg::ST_RD: rvalid_ff <= valid_ff[ram_addr];
         bce_pkg::ST_LO: begin
            acc_ff <= prod_x;
            pa_ff  <= rvalid_ff ? $signed(ram_rdata[4*PT-1:3*PT]) : '0;
            pn_ff  <= rvalid_ff ? $signed(ram_rdata[3*PT-1:2*PT]) : '0;
            pm_ff  <= rvalid_ff ? $signed(ram_rdata[2*PT-1:PT])   : '0;
            po_ff  <= rvalid_ff ? $signed(ram_rdata[PT-1:0])      : '0;
         end
         bce_pkg::ST_ACC: pa_ff <= anew_w[PT-1:0];
         bce_pkg::ST_SHIFT: begin
            // shift history, newest gets the shrunk accumulator
            po_ff <= pm_ff;
            pm_ff <= pn_ff;
            pn_ff <= PT'(bce_pkg::sat_w(prod_x >>> 16, PT));
            pa_ff <= '0;
         end
         bce_pkg::ST_WC: w0_ff <= 18'(prod[33:16]);
         bce_pkg::ST_WB: w1_ff <= 18'(prod[32:15]);
         bce_pkg::ST_BD: begin
            w2_ff  <= 18'(prod[33:16]);
            acc_ff <= AC'(pm_ff) <<< 16;
         end
         bce_pkg::ST_BC, bce_pkg::ST_BB, bce_pkg::ST_BE: acc_ff <= acc_ff + prod_x;
         bce_pkg::ST_OUT: begin
            band_ff[s_ff] <= band_w[SIG_W-1:0];
            in_ff         <= o_w[SIG_W-1:0];
            if (s_ff == 2'd2) band_ff[3] <= o_w[SIG_W-1:0];
            s_ff <= s_ff + 2'd1;
            k_ff <= '0;
         end
         bce_pkg::ST_MX: begin
            acc_ff <= (k_ff == 2'd0) ? '0 : mix_w;
            k_ff   <= k_ff + 2'd1;
         end
         bce_pkg::ST_MXE: begin
            x_ff[ch_ff] <= mixo_w[SIG_W-1:0];
            s_ff        <= '0;
            k_ff        <= '0;
            if (!ch_ff) begin
               ch_ff <= 1'b1;
               in_ff <= x_ff[1];
            end else begin
               ch_ff <= 1'b0;
               p_ff  <= p_ff + PW'(1);
               if (p_ff == PW'(PASSES - 1)) begin
                  out_left_ff  <= SAMPLE_BITS'(bce_pkg::sat_w(AC'(x_ff[0]), SAMPLE_BITS));
                  out_right_ff <= SAMPLE_BITS'(bce_pkg::sat_w(mixo_w, SAMPLE_BITS));
               end
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire
